// ----- sv/tdfm_pkg.sv -----
// shared constants, types and tile transform functions for the tile dedup block
package tdfm_pkg;

   localparam int TABLE_DEPTH    = 512;
   localparam int IDX_W          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W          = $clog2(TABLE_DEPTH + 1);
   localparam int HALF_W         = 64;
   localparam int TILE_W         = 2 * HALF_W;
   localparam int BYTE_W         = 8;
   localparam int TILE_BYTES     = TILE_W / BYTE_W;
   localparam int ROW_W          = 16;
   localparam int TILE_ROWS      = TILE_W / ROW_W;
   localparam int ENTRY_INDEX_W  = 9;
   localparam int ENTRIES_USED_W = 10;
   localparam int OUTCOME_W      = 2;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

   typedef logic [TILE_W-1:0] tile_type;

   typedef enum logic [OUTCOME_W-1:0] {
      OUTCOME_MATCHED = 2'd0,
      OUTCOME_STORED  = 2'd1,
      OUTCOME_FULL    = 2'd2
   } outcome_type;

   typedef struct packed {
      tile_type plain;
      tile_type horiz;
      tile_type vert;
      tile_type both;
   } forms_type;

   typedef struct packed {
      logic      avail;
      forms_type forms;
   } job_type;

   typedef struct packed {
      logic [ENTRY_INDEX_W-1:0]  entry_index;
      logic                      mirror_x;
      logic                      mirror_y;
      outcome_type               outcome;
      logic [ENTRIES_USED_W-1:0] entries_used;
   } result_type;

   // bit order reversed inside every byte
   function automatic tile_type mirror_bytes(input tile_type t);
      tile_type r;
      r = '0;
      for (int b = 0; b < TILE_BYTES; b++) begin
         for (int k = 0; k < BYTE_W; k++) begin
            r[b*BYTE_W + k] = t[b*BYTE_W + (BYTE_W - 1 - k)];
         end
      end
      return r;
   endfunction

   // order of the two-byte rows reversed
   function automatic tile_type mirror_rows(input tile_type t);
      tile_type r;
      r = '0;
      for (int w = 0; w < TILE_ROWS; w++) begin
         r[w*ROW_W +: ROW_W] = t[(TILE_ROWS - 1 - w)*ROW_W +: ROW_W];
      end
      return r;
   endfunction

   function automatic forms_type make_forms(input tile_type t);
      forms_type f;
      f.plain = t;
      f.horiz = mirror_bytes(t);
      f.vert  = mirror_rows(t);
      f.both  = mirror_rows(mirror_bytes(t));
      return f;
   endfunction

endpackage

// ----- sv/tile_dedup_flip_match.sv -----
// Tile deduplication store with flip matching. Each request beat carries one
// 16-byte two-plane 8x8 tile; the response beat gives the index of the first
// stored entry that equals the tile as is, mirrored horizontally, vertically or
// both (with the flip flags), or the index where the tile was appended, or a
// store-full outcome. Tiles are processed one at a time: the search walks the
// N entries stored so far (up to 512) through the single store read port, one
// entry per cycle from index 0, and stops early at the first hit. Two-beat
// queues on both sides let requests be taken and responses be held while a
// search runs.
module tile_dedup_flip_match (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic [63:0]                            req_tile_low,
   input  logic [63:0]                            req_tile_high,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic [tdfm_pkg::ENTRY_INDEX_W-1:0]     rsp_entry_index,
   output logic                                   rsp_mirror_x,
   output logic                                   rsp_mirror_y,
   output logic [tdfm_pkg::OUTCOME_W-1:0]         rsp_outcome,
   output logic [tdfm_pkg::ENTRIES_USED_W-1:0]    rsp_entries_used
);
   import tdfm_pkg::*;

   job_type    job;
   logic       take;
   logic       result_push;
   result_type result;
   logic       rsp_room_full;
   result_type head;

   tdfm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_tile_low  (req_tile_low),
      .req_tile_high (req_tile_high),
      .take          (take),
      .job           (job)
   );

   tdfm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job           (job),
      .take          (take),
      .rsp_room_full (rsp_room_full),
      .result_push   (result_push),
      .result        (result)
   );

   tdfm_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (result),
      .full      (rsp_room_full),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .head      (head)
   );

   assign rsp_entry_index  = head.entry_index;
   assign rsp_mirror_x     = head.mirror_x;
   assign rsp_mirror_y     = head.mirror_y;
   assign rsp_outcome      = head.outcome;
   assign rsp_entries_used = head.entries_used;

endmodule

// ----- sv/tdfm_ram.sv -----
// generic simple dual-port ram with registered read
module tdfm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/tdfm_front.sv -----
// request queue and forming of the four mirrored variants of the queued tile
module tdfm_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [63:0]             req_tile_low,
   input  logic [63:0]             req_tile_high,
   input  logic                    take,
   output tdfm_pkg::job_type       job
);
   import tdfm_pkg::*;

   tile_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              push_ok;
   logic              pop_ok;

   assign req_full = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = take && (cnt_ff != '0);

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= {req_tile_high, req_tile_low};
      end
   end

   assign job.avail = (cnt_ff != '0);
   assign job.forms = make_forms(slot_ff[rd_ptr_ff]);

endmodule

// ----- sv/tdfm_back.sv -----
// search engine: walks the tile store one entry per cycle and appends on a miss unless the store is full
module tdfm_back (
   input  logic                 clock,
   input  logic                 reset,
   input  tdfm_pkg::job_type    job,
   output logic                 take,
   input  logic                 rsp_room_full,
   output logic                 result_push,
   output tdfm_pkg::result_type result
);
   import tdfm_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type         state_ff, state_in;
   forms_type         forms_ff, forms_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              push_ff, push_in;
   result_type        result_ff, result_in;

   logic              issue;
   logic              wr_en;
   tile_type          rd_data;
   logic              hit_plain, hit_horiz, hit_vert, hit_both, hit_any;

   assign issue     = (state_ff == S_SCAN) && (scan_ff < count_ff);
   assign hit_plain = (rd_data == forms_ff.plain);
   assign hit_horiz = (rd_data == forms_ff.horiz);
   assign hit_vert  = (rd_data == forms_ff.vert);
   assign hit_both  = (rd_data == forms_ff.both);
   assign hit_any   = cmp_valid_ff && (hit_plain || hit_horiz || hit_vert || hit_both);

   always_comb begin
      state_in     = state_ff;
      forms_in     = forms_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      cmp_valid_in = cmp_valid_ff;
      cmp_idx_in   = cmp_idx_ff;
      push_in      = 1'b0;
      result_in    = result_ff;
      take         = 1'b0;
      wr_en        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (job.avail && !rsp_room_full && !push_ff) begin
               take         = 1'b1;
               forms_in     = job.forms;
               scan_in      = '0;
               cmp_valid_in = 1'b0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            if (hit_any) begin
               result_in.entry_index  = ENTRY_INDEX_W'(cmp_idx_ff);
               result_in.mirror_x     = !hit_plain && (hit_horiz || (!hit_vert && hit_both));
               result_in.mirror_y     = !hit_plain && !hit_horiz;
               result_in.outcome      = OUTCOME_MATCHED;
               result_in.entries_used = ENTRIES_USED_W'(count_ff);
               push_in      = 1'b1;
               cmp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end else if (!issue && !cmp_valid_ff) begin
               if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                  result_in.entry_index  = '0;
                  result_in.outcome      = OUTCOME_FULL;
                  result_in.entries_used = ENTRIES_USED_W'(count_ff);
               end else begin
                  wr_en                  = 1'b1;
                  count_in               = count_ff + 1'b1;
                  result_in.entry_index  = ENTRY_INDEX_W'(count_ff);
                  result_in.outcome      = OUTCOME_STORED;
                  result_in.entries_used = ENTRIES_USED_W'(count_in);
               end
               result_in.mirror_x = 1'b0;
               result_in.mirror_y = 1'b0;
               push_in            = 1'b1;
               state_in           = S_IDLE;
            end else begin
               cmp_valid_in = issue;
               cmp_idx_in   = scan_ff[IDX_W-1:0];
               if (issue) begin
                  scan_in = scan_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         push_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         push_ff      <= push_in;
      end
      forms_ff   <= forms_in;
      scan_ff    <= scan_in;
      cmp_idx_ff <= cmp_idx_in;
      result_ff  <= result_in;
   end

   tdfm_ram #(
      .WIDTH (TILE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (forms_ff.plain),
      .rd_en   (issue),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign result_push = push_ff;
   assign result      = result_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond store depth");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (count_ff < CNT_W'(TABLE_DEPTH)) && !hit_any)
      else $error("append while full or after a hit");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_ff |-> !rsp_room_full)
      else $error("result beat pushed into full queue");

   a_cmp_follows_read: assert property (@(posedge clock) disable iff (reset)
      (cmp_valid_ff && !$past(reset)) |-> $past(issue))
      else $error("compare without a store read the cycle before");

endmodule

// ----- sv/tdfm_rsp_queue.sv -----
// result queue between the search engine and the response port
module tdfm_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tdfm_pkg::result_type push_data,
   output logic                 full,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output tdfm_pkg::result_type head
);
   import tdfm_pkg::*;

   result_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              push_ok;
   logic              pop_ok;

   assign full      = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign rsp_empty = (cnt_ff == '0);
   assign push_ok   = push && !full;
   assign pop_ok    = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head = slot_ff[rd_ptr_ff];

endmodule
